// ===== rtl/graph_walk_counter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for graph_walk_counter_unit
// Shared concurrent checks, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRAPH_WALK_COUNTER_UNIT_ASSERT_SVH
`define GRAPH_WALK_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GWC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gwc_pkg.sv =====
// ----------------------------------------------------------------------------
// gwc_pkg
// Types, codes and widths shared by the walk counter block.
// ----------------------------------------------------------------------------
package gwc_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_COUNT_WIDTH  = 64;

    localparam int KIND_W      = 2;
    localparam int VERT_W      = 4;
    localparam int VCOUNT_W    = 5;
    localparam int PLEN_W      = 4;
    localparam int WALK_W      = 64;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;
    localparam logic [PLEN_W-1:0]   PLEN_RESET   = 4'd1;

    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATH_LENGTH  = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_SAT   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_MUL,
        ST_DRAIN,
        ST_LOOKUP,
        ST_CAPTURE,
        ST_EMIT
    } gwc_state_t;

    // Sequencer to matrix store control
    typedef struct packed {
        logic rd_en;
        logic fill_we;
        logic fill_bit;
        logic mac_issue;
        logic mac_edge;
        logic mac_first;
        logic mac_last;
    } gwc_mem_ctrl_t;

endpackage

// ===== rtl/gwc_item_if.sv =====
// ----------------------------------------------------------------------------
// gwc_item_if
// Input item channel: edge add, walk query or graph clear.
// ----------------------------------------------------------------------------
interface gwc_item_if;
    import gwc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [VERT_W-1:0] from_vertex;
    logic [VERT_W-1:0] to_vertex;

    modport source (output valid, output kind, output from_vertex, output to_vertex,
                    input ready);
    modport sink   (input valid, input kind, input from_vertex, input to_vertex,
                    output ready);
endinterface

// ===== rtl/gwc_result_if.sv =====
// ----------------------------------------------------------------------------
// gwc_result_if
// Result channel: walk count and status, one transfer per input item.
// ----------------------------------------------------------------------------
interface gwc_result_if;
    import gwc_pkg::*;

    logic                valid;
    logic                ready;
    logic [WALK_W-1:0]   walk_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output walk_count, output status, input ready);
    modport sink   (input valid, input walk_count, input status, output ready);
endinterface

// ===== rtl/gwc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gwc_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface gwc_cfg_if;
    import gwc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/gwc_matrix_mac.sv =====
// ----------------------------------------------------------------------------
// gwc_matrix_mac
// Ping-pong matrix store with one saturating multiply-accumulate stage.
// ----------------------------------------------------------------------------
`include "graph_walk_counter_unit_assert.svh"

module gwc_matrix_mac #(
    parameter int MAX_VERTICES = gwc_pkg::DEF_MAX_VERTICES,
    parameter int COUNT_WIDTH  = gwc_pkg::DEF_COUNT_WIDTH,
    parameter int AW           = 2 * $clog2(MAX_VERTICES) + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gwc_pkg::gwc_mem_ctrl_t ctrl,
    input  logic [AW-1:0]         rd_addr,
    input  logic [AW-1:0]         wr_addr,
    output logic [COUNT_WIDTH-1:0] rd_data
);
    import gwc_pkg::*;

    localparam int DEPTH = 1 << AW;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] rd_data_reg;

    logic          s1_valid_reg;
    logic          s1_edge_reg;
    logic          s1_first_reg;
    logic          s1_last_reg;
    logic [AW-1:0] s1_waddr_reg;

    logic [COUNT_WIDTH-1:0] acc_reg;
    logic [COUNT_WIDTH-1:0] acc_next;
    logic [COUNT_WIDTH-1:0] acc_base;
    logic [COUNT_WIDTH-1:0] addend;
    logic [COUNT_WIDTH:0]   sum;

    assign rd_data = rd_data_reg;

    // Saturating accumulate: a carry out means the sum passed the maximum
    always_comb
    begin
        acc_base = s1_first_reg ? '0 : acc_reg;
        addend   = s1_edge_reg ? rd_data_reg : '0;
        sum      = {1'b0, acc_base} + {1'b0, addend};
        acc_next = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (ctrl.fill_we)
        begin
            mem[wr_addr] <= COUNT_WIDTH'(ctrl.fill_bit);
        end
        else if (s1_valid_reg && s1_last_reg)
        begin
            mem[s1_waddr_reg] <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.mac_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_edge_reg  <= ctrl.mac_edge;
        s1_first_reg <= ctrl.mac_first;
        s1_last_reg  <= ctrl.mac_last;
        s1_waddr_reg <= wr_addr;
        if (s1_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    `GWC_ASSERT_IMPL(a_no_write_clash, ctrl.fill_we, !(s1_valid_reg && s1_last_reg), "write clash")
    `GWC_ASSERT_IMPL(a_issue_reads, ctrl.mac_issue, ctrl.rd_en, "term issued without a read")
    `GWC_ASSERT_NEXT(a_row_contiguous, s1_valid_reg && !s1_last_reg, s1_valid_reg, "row broken")

endmodule

// ===== rtl/graph_walk_counter_unit.sv =====
// ----------------------------------------------------------------------------
// graph_walk_counter_unit
// Counts directed walks of a set length between two vertices of a small graph.
// ----------------------------------------------------------------------------
// Edge adds, clears, out-of-range items and unused kinds go straight to the
// result register. A query on an up-to-date power matrix reads the stored
// entry. The first query after any edge change, clear or register write
// rebuilds A^L with n active vertices and L = path_length: a fill of n*n
// entries, then L-1 matrix products, then the lookup. The rebuild time is set
// by the single saturating multiply-accumulate unit, which takes one term per
// cycle from the one read port of the matrix store. Input and register writes
// are taken only while no item is in progress; a finished result waits in an
// output register.
// ----------------------------------------------------------------------------
`include "graph_walk_counter_unit_assert.svh"

module graph_walk_counter_unit #(
    parameter int MAX_VERTICES = gwc_pkg::DEF_MAX_VERTICES,
    parameter int COUNT_WIDTH  = gwc_pkg::DEF_COUNT_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    gwc_item_if.sink     item,
    gwc_result_if.source result,
    gwc_cfg_if.sink      cfg
);
    import gwc_pkg::*;

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int NW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = NW + VERT_W;
    localparam int VCW  = NW + VCOUNT_W;
    localparam int AW   = 2 * VW + 1;

    gwc_state_t state_reg, state_next;

    logic [VCOUNT_W-1:0] vertex_count_reg;
    logic [PLEN_W-1:0]   path_length_reg;
    logic [MAX_VERTICES-1:0][MAX_VERTICES-1:0] adj_reg;
    logic power_valid_reg, power_valid_next;

    logic [VERT_W-1:0] from_reg, to_reg;
    logic [VW-1:0]     i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [PLEN_W-1:0] step_reg, step_next, step_inc;
    logic              bank_reg, bank_next;

    logic [COUNT_WIDTH-1:0] res_count_reg, res_count_next;
    status_t                res_status_reg, res_status_next;

    logic                out_valid_reg;
    logic [WALK_W-1:0]   out_count_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_load;

    logic [NW-1:0] n_act, n_last;
    logic          i_last, j_last, k_last;
    logic          item_fire, cfg_fire;
    logic          from_ok, to_ok;
    logic          adj_set, adj_clear;
    logic [VW-1:0] from_idx, to_idx;

    gwc_mem_ctrl_t          ctrl;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic [COUNT_WIDTH-1:0] rd_data;

    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = (state_reg == ST_IDLE);
    assign item_fire  = item.valid && item.ready;
    assign cfg_fire   = cfg.valid && cfg.ready;

    assign result.valid      = out_valid_reg;
    assign result.walk_count = out_count_reg;
    assign result.status     = out_status_reg;

    // Active vertex count is vertex_count clamped to the array size
    always_comb
    begin
        if (VCW'(vertex_count_reg) > VCW'(MAX_VERTICES))
        begin
            n_act = NW'(MAX_VERTICES);
        end
        else
        begin
            n_act = NW'(vertex_count_reg);
        end
        n_last = n_act - NW'(1);
    end

    assign from_ok  = CMPW'(item.from_vertex) < CMPW'(n_act);
    assign to_ok    = CMPW'(item.to_vertex) < CMPW'(n_act);
    assign from_idx = VW'(item.from_vertex);
    assign to_idx   = VW'(item.to_vertex);

    assign i_last   = (NW'(i_reg) == n_last);
    assign j_last   = (NW'(j_reg) == n_last);
    assign k_last   = (NW'(k_reg) == n_last);
    assign step_inc = step_reg + PLEN_W'(1);

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if ((item.kind == KIND_QUERY) && from_ok && to_ok)
                    begin
                        state_next = power_valid_reg ? ST_LOOKUP : ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FILL:
            begin
                if (i_last && j_last)
                begin
                    state_next = (path_length_reg <= PLEN_W'(1)) ? ST_LOOKUP : ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (i_last && j_last && k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = (step_inc == path_length_reg) ? ST_LOOKUP : ST_MUL;
            end
            ST_LOOKUP:
            begin
                state_next = ST_CAPTURE;
            end
            ST_CAPTURE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and datapath next values
    always_comb
    begin
        ctrl             = '0;
        rd_addr          = {bank_reg, i_reg, k_reg};
        wr_addr          = {~bank_reg, i_reg, j_reg};
        i_next           = i_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        step_next        = step_reg;
        bank_next        = bank_reg;
        power_valid_next = power_valid_reg;
        res_count_next   = res_count_reg;
        res_status_next  = res_status_reg;
        adj_set          = 1'b0;
        adj_clear        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                i_next          = '0;
                j_next          = '0;
                k_next          = '0;
                res_count_next  = '0;
                res_status_next = STATUS_OK;
                if (item_fire)
                begin
                    unique case (item.kind)
                        KIND_ADD:
                        begin
                            if (from_ok && to_ok)
                            begin
                                adj_set          = 1'b1;
                                power_valid_next = 1'b0;
                            end
                            else
                            begin
                                res_status_next = STATUS_RANGE;
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (!(from_ok && to_ok))
                            begin
                                res_status_next = STATUS_RANGE;
                            end
                            else if (!power_valid_reg)
                            begin
                                bank_next = 1'b0;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            adj_clear        = 1'b1;
                            power_valid_next = 1'b0;
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                // Seed bank 0 with A, or with the identity for a zero length
                ctrl.fill_we  = 1'b1;
                ctrl.fill_bit = (path_length_reg == '0) ? (i_reg == j_reg)
                                                        : adj_reg[i_reg][j_reg];
                wr_addr       = {1'b0, i_reg, j_reg};
                step_next     = PLEN_W'(1);
                if (j_last)
                begin
                    j_next = '0;
                    i_next = i_last ? '0 : i_reg + VW'(1);
                end
                else
                begin
                    j_next = j_reg + VW'(1);
                end
            end
            ST_MUL:
            begin
                // One term P[i][k] * A[k][j] per cycle, k innermost
                ctrl.rd_en     = 1'b1;
                ctrl.mac_issue = 1'b1;
                ctrl.mac_edge  = adj_reg[k_reg][j_reg];
                ctrl.mac_first = (k_reg == '0);
                ctrl.mac_last  = k_last;
                if (k_last)
                begin
                    k_next = '0;
                    if (j_last)
                    begin
                        j_next = '0;
                        i_next = i_last ? '0 : i_reg + VW'(1);
                    end
                    else
                    begin
                        j_next = j_reg + VW'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + VW'(1);
                end
            end
            ST_DRAIN:
            begin
                bank_next = ~bank_reg;
                step_next = step_inc;
            end
            ST_LOOKUP:
            begin
                ctrl.rd_en       = 1'b1;
                rd_addr          = {bank_reg, VW'(from_reg), VW'(to_reg)};
                power_valid_next = 1'b1;
            end
            ST_CAPTURE:
            begin
                res_count_next  = rd_data;
                res_status_next = (rd_data == {COUNT_WIDTH{1'b1}}) ? STATUS_SAT : STATUS_OK;
            end
            ST_EMIT:
            begin
                ctrl = '0;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase

        if (cfg_fire && ((cfg.index == REG_VERTEX_COUNT) || (cfg.index == REG_PATH_LENGTH)))
        begin
            power_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            vertex_count_reg <= VCOUNT_RESET;
            path_length_reg  <= PLEN_RESET;
            adj_reg          <= '0;
            power_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            step_reg         <= '0;
            bank_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            power_valid_reg <= power_valid_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            k_reg           <= k_next;
            step_reg        <= step_next;
            bank_reg        <= bank_next;

            if (cfg_fire)
            begin
                unique case (cfg.index)
                    REG_VERTEX_COUNT: vertex_count_reg <= cfg.data;
                    REG_PATH_LENGTH:  path_length_reg  <= cfg.data[PLEN_W-1:0];
                    default:          vertex_count_reg <= vertex_count_reg;
                endcase
            end

            if (adj_clear)
            begin
                adj_reg <= '0;
            end
            else if (adj_set)
            begin
                adj_reg[from_idx][to_idx] <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        if (item_fire)
        begin
            from_reg <= item.from_vertex;
            to_reg   <= item.to_vertex;
        end
        if (out_load)
        begin
            out_count_reg  <= WALK_W'(res_count_reg);
            out_status_reg <= res_status_reg;
        end
    end

    gwc_matrix_mac #(
        .MAX_VERTICES (MAX_VERTICES),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .AW           (AW)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .rd_data (rd_data)
    );

    `GWC_ASSERT_IMPL(a_load_from_emit, $rose(out_valid_reg), $past(state_reg == ST_EMIT), "result raised outside emit")
    `GWC_ASSERT_IMPL(a_lookup_in_range, state_reg == ST_LOOKUP, (CMPW'(from_reg) < CMPW'(n_act)) && (CMPW'(to_reg) < CMPW'(n_act)), "lookup of an inactive vertex")
    `GWC_ASSERT_IMPL(a_step_bound, state_reg == ST_MUL, step_reg < path_length_reg, "product step beyond path length")

endmodule
